// ===== sv/grid_diagonal_scan_marker_macros.svh =====
// assertion macros for the grid diagonal scan marker
`ifndef GRID_DIAGONAL_SCAN_MARKER_MACROS_SVH
`define GRID_DIAGONAL_SCAN_MARKER_MACROS_SVH

`ifndef ASSERT_OFF
`define GDSM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GDSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDSM_ASSERT(lbl, clk, rst, prop, msg)
`define GDSM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/gdsm_pkg.sv =====
`default_nettype none

package gdsm_pkg;

  localparam int ACTION_W   = 2;
  localparam int POS_W      = 6;
  localparam int RUN_W      = 6;
  localparam int BYTE_W     = 8;
  localparam int CLIP_W     = 2;
  localparam int REG_W      = 7;
  localparam int MASK_W     = 32;
  localparam int MASK_IDX_W = 5;
  localparam int COORD_W    = 8;
  localparam int PROD_W     = 14;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [ACTION_W-1:0] ACT_READ       = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE      = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DIAG_WRITE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_DIAG_SCAN  = 2'd3;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] GRID_RESET = 7'd64;

  localparam logic [BYTE_W-1:0] CELL_WALL = 8'h23;
  localparam logic [BYTE_W-1:0] CELL_CLIP = 8'h75;
  localparam logic [BYTE_W-1:0] CELL_OPEN = 8'h6F;

  typedef struct packed {
    logic             valid;
    logic             on_grid;
    logic             first;
    logic             last;
    logic [RUN_W-1:0] k;
  } step_t;

endpackage

`default_nettype wire

// ===== sv/gdsm_cell_ram.sv =====
`default_nettype none

module gdsm_cell_ram
  import gdsm_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int A_W   = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [A_W-1:0]    wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [A_W-1:0]    rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/gdsm_addr_stage.sv =====
`default_nettype none

module gdsm_addr_stage
  import gdsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int A_W        = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [REG_W-1:0] grid_width,
  input  logic [REG_W-1:0] grid_height,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  input  step_t            step_in,
  output step_t            step_out,
  output logic [A_W-1:0]   addr_out
);

  logic [REG_W-1:0]   eff_w;
  logic [REG_W-1:0]   eff_h;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  lin;
  logic               on_grid;

  assign eff_w = (32'(grid_width) > MAX_WIDTH) ? REG_W'(MAX_WIDTH) : grid_width;
  assign eff_h = (32'(grid_height) > MAX_HEIGHT) ? REG_W'(MAX_HEIGHT) : grid_height;

  // x falls, y rises along the anti-diagonal
  assign cx = COORD_W'(pos_x) - COORD_W'(step_in.k);
  assign cy = COORD_W'(pos_y) + COORD_W'(step_in.k);

  assign on_grid = !cx[COORD_W-1] && (cx[REG_W-1:0] < eff_w)
                   && (cy < COORD_W'(eff_h));

  assign prod = PROD_W'(eff_w) * PROD_W'(cy[REG_W-1:0]);
  assign lin  = prod + PROD_W'(cx[REG_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out.valid <= 1'b0;
    end else begin
      step_out.valid <= step_in.valid;
    end
    step_out.on_grid <= on_grid;
    step_out.first   <= step_in.first;
    step_out.last    <= step_in.last;
    step_out.k       <= step_in.k;
    addr_out         <= A_W'(lin);
  end

endmodule

`default_nettype wire

// ===== sv/grid_diagonal_scan_marker.sv =====
`default_nettype none
`include "grid_diagonal_scan_marker_macros.svh"

// Byte-per-cell grid of MAX_WIDTH*MAX_HEIGHT cells in one simple dual-port
// synchronous RAM, addressed as grid_width*y + x. Actions: read a cell, write a
// cell, write a byte along the anti-diagonal, or scan the anti-diagonal
// (walls set wall_mask bits, other cells become 'u' or 'o'). Items are taken
// one at a time: a diagonal is walked one address per cycle through the address
// stage, then each step passes the RAM read and the write-back stage before the
// result is loaded. The RAM's single read and single write port set that pace.
// The next item is accepted while a result still waits in the output register.
// Cells hold nothing defined until written; there is no clearing pass after
// reset.
module grid_diagonal_scan_marker
  import gdsm_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_RUN    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  // action, pos_x, pos_y, run_length, write_data, corner_clips
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // read_data, wall_mask, out_of_range
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int A_W   = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [REG_W-1:0]    grid_width;
  logic [REG_W-1:0]    grid_height;

  logic [ACTION_W-1:0] in_action;
  logic [POS_W-1:0]    in_pos_x;
  logic [POS_W-1:0]    in_pos_y;
  logic [RUN_W-1:0]    in_run_length;
  logic [BYTE_W-1:0]   in_write_data;
  logic [CLIP_W-1:0]   in_corner_clips;
  logic [RUN_W-1:0]    in_run;

  logic [ACTION_W-1:0] op;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [BYTE_W-1:0]   wdata;
  logic [CLIP_W-1:0]   clips;
  logic [RUN_W-1:0]    run;
  logic [RUN_W-1:0]    k;

  step_t               gen;
  step_t               s1;
  step_t               s2;
  logic [A_W-1:0]      s1_addr;
  logic [A_W-1:0]      s2_addr;

  logic                rd_en;
  logic [BYTE_W-1:0]   rd_data;
  logic                wr_s1;
  logic                wr_s2;
  logic                wr_en;
  logic [A_W-1:0]      wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic [BYTE_W-1:0]   mark;

  logic [BYTE_W-1:0]   rdata_acc;
  logic [MASK_W-1:0]   mask_acc;
  logic                oor_acc;
  logic                accept;
  logic                load_out;

  assign in_action       = s_tdata[1:0];
  assign in_pos_x        = s_tdata[7:2];
  assign in_pos_y        = s_tdata[13:8];
  assign in_run_length   = s_tdata[19:14];
  assign in_write_data   = s_tdata[27:20];
  assign in_corner_clips = s_tdata[29:28];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    case (in_action) inside
      ACT_READ, ACT_WRITE: in_run = RUN_W'(1);
      default: begin
        in_run = (32'(in_run_length) > MAX_RUN) ? RUN_W'(MAX_RUN) : in_run_length;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
      endcase
    end
  end

  // step generator
  assign gen.valid   = (state == ST_RUN);
  assign gen.on_grid = 1'b0;
  assign gen.first   = (k == '0);
  assign gen.last    = (RUN_W'(k + 1'b1) == run);
  assign gen.k       = k;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (in_run == '0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (gen.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1.valid && !s2.valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= in_action;
      pos_x <= in_pos_x;
      pos_y <= in_pos_y;
      wdata <= in_write_data;
      clips <= in_corner_clips;
      run   <= in_run;
      k     <= '0;
    end else if (state == ST_RUN) begin
      k <= RUN_W'(k + 1'b1);
    end
  end

  gdsm_addr_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .A_W        (A_W)
  ) u_addr_stage (
    .clk         (clk),
    .rst         (rst),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .step_in     (gen),
    .step_out    (s1),
    .addr_out    (s1_addr)
  );

  // plain writes go out from the address stage, scan write-back in the cycle after
  assign rd_en = s1.valid && s1.on_grid && ((op == ACT_READ) || (op == ACT_DIAG_SCAN));
  assign wr_s1 = s1.valid && s1.on_grid && ((op == ACT_WRITE) || (op == ACT_DIAG_WRITE));
  assign wr_s2 = s2.valid && s2.on_grid && (op == ACT_DIAG_SCAN) && (rd_data != CELL_WALL);

  assign mark = ((s2.first && clips[0]) || (s2.last && clips[1])) ? CELL_CLIP : CELL_OPEN;

  assign wr_en   = wr_s1 || wr_s2;
  assign wr_addr = wr_s2 ? s2_addr : s1_addr;
  assign wr_data = wr_s2 ? mark : wdata;

  gdsm_cell_ram #(
    .DEPTH (DEPTH),
    .A_W   (A_W)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (s1_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.on_grid <= s1.on_grid;
    s2.first   <= s1.first;
    s2.last    <= s1.last;
    s2.k       <= s1.k;
    s2_addr    <= s1_addr;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_acc <= '0;
      mask_acc  <= '0;
      oor_acc   <= 1'b0;
    end else if (s2.valid) begin
      if (!s2.on_grid) begin
        oor_acc <= 1'b1;
      end else begin
        case (op)
          ACT_READ:      rdata_acc <= rd_data;
          ACT_DIAG_SCAN: begin
            if (rd_data == CELL_WALL) begin
              mask_acc[s2.k[MASK_IDX_W-1:0]] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {7'd0, oor_acc, mask_acc, rdata_acc};
    end
  end

  `GDSM_ASSERT(a_no_rw_same_cell, clk, rst, (rd_en && wr_en) |-> (s1_addr != wr_addr), "read and write hit the same cell")
  `GDSM_ASSERT(a_idle_pipe_empty, clk, rst, s_tready |-> (!s1.valid && !s2.valid), "item taken with steps in flight")
  `GDSM_ASSERT(a_s2_follows_s1, clk, rst, s2.valid |-> $past(s1.valid), "write-back stage without address stage")
  `GDSM_ASSERT(a_load_only_drained, clk, rst, load_out |-> (!s1.valid && !s2.valid), "result loaded before write-back")
  `GDSM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !m_tvalid), "not idle after reset")

endmodule

`default_nettype wire
